FILE: design/slfqm_pkg.sv
// Shared constants, codes and word tables for the serial line framer.
package slfqm_pkg;

    // Buffer capacity and derived counter width
    localparam int MAX_LEN = 64;
    localparam int FILL_W  = $clog2(MAX_LEN + 1);

    // Output field widths
    localparam int EVENT_W = 2;
    localparam int LEN_W   = 7;
    localparam int KIND_W  = 3;
    localparam int INDEX_W = 6;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Frame event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_EXECUTE  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DEFER    = 2'd2;
    localparam logic [EVENT_W-1:0] EV_OVERFLOW = 2'd3;

    // Terminator swallowing modes
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_LF   = 2'd1;
    localparam logic [1:0] TAIL_ANY  = 2'd2;

    // Matcher phases
    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_WORD  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;
    localparam logic [1:0] PH_FAIL  = 2'd3;

    // Query word codes
    localparam logic [KIND_W-1:0] QK_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] QK_STB   = 3'd1;
    localparam logic [KIND_W-1:0] QK_IB    = 3'd2;
    localparam logic [KIND_W-1:0] QK_BUILD = 3'd3;
    localparam logic [KIND_W-1:0] QK_OPT   = 3'd4;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            u = c - 8'd32;
        end
        return u;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // Word index is (code - 1) & 3
    function automatic logic [2:0] word_len(input logic [1:0] w);
        logic [2:0] n;
        unique case (w)
            2'd0:    n = 3'd3;
            2'd1:    n = 3'd2;
            2'd2:    n = 3'd5;
            default: n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (w)
            2'd0: begin
                unique case (pos)
                    3'd0:    ch = 8'h53; // S
                    3'd1:    ch = 8'h54; // T
                    3'd2:    ch = 8'h42; // B
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (pos)
                    3'd0:    ch = 8'h49; // I
                    3'd1:    ch = 8'h42; // B
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (pos)
                    3'd0:    ch = 8'h42; // B
                    3'd1:    ch = 8'h55; // U
                    3'd2:    ch = 8'h49; // I
                    3'd3:    ch = 8'h4C; // L
                    3'd4:    ch = 8'h44; // D
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    ch = 8'h4F; // O
                    3'd1:    ch = 8'h50; // P
                    3'd2:    ch = 8'h54; // T
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

FILE: design/serial_line_framer_query_match_core.sv
// Serial line framer: per-character frame delimiting, byte store reporting and query matching.
// Each accepted input transaction has its result on the output register in the following cycle.
// Throughput: one character per cycle while the receiver keeps the result register drained; the
// framing and match state update in a single pass between the input handshake and the result register.
// The input is ready whenever the result register is empty or being drained this cycle.
// Reset (synchronous, active low) clears the swallow mode, fill count, overflow flag,
// matcher state and the output valid; result payload registers are not reset.
module serial_line_framer_query_match_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_frame_event,
    output logic       o_frame_marker,
    output logic [6:0] o_frame_length,
    output logic [2:0] o_query_kind,
    output logic       o_byte_stored,
    output logic [5:0] o_store_index,
    output logic [7:0] o_stored_byte
);

    // Framing state
    logic [1:0]                   r_tail, n_tail;
    logic [slfqm_pkg::FILL_W-1:0] r_fill, n_fill;
    logic                         r_ovf, n_ovf;

    // On-the-fly matcher state
    logic [1:0] r_phase, n_phase;
    logic [2:0] r_word, n_word;
    logic [2:0] r_pos, n_pos;

    // Result register
    logic       r_out_valid;
    logic [1:0] r_event, n_event;
    logic       r_marker, n_marker;
    logic [6:0] r_length, n_length;
    logic [2:0] r_kind, n_kind;
    logic       r_stored, n_stored;
    logic [5:0] r_index, n_index;
    logic [7:0] r_byte, n_byte;

    // Matcher next values when the character is appended
    logic [1:0] m_phase;
    logic [2:0] m_word;
    logic [2:0] m_pos;

    logic       in_fire;
    logic [7:0] upper_c;
    logic [1:0] cur_w;
    logic [2:0] cur_len;

    // Result register frees up as it drains, so a new transaction can enter every cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign upper_c = slfqm_pkg::to_upper(i_char_in);
    assign cur_w   = 2'(r_word - 3'd1);
    assign cur_len = slfqm_pkg::word_len(cur_w);

    // Matcher step: leading blanks, then the word letter by letter, then trailing blanks
    always_comb begin
        m_phase = r_phase;
        m_word  = r_word;
        m_pos   = r_pos;
        unique case (r_phase)
            slfqm_pkg::PH_LEAD: begin
                if (!slfqm_pkg::is_blank(i_char_in)) begin
                    m_phase = slfqm_pkg::PH_FAIL;
                    // first letters are distinct across the four words
                    if (upper_c == slfqm_pkg::word_char(2'd0, 3'd0)) begin
                        m_word  = slfqm_pkg::QK_STB;
                        m_pos   = 3'd1;
                        m_phase = slfqm_pkg::PH_WORD;
                    end else if (upper_c == slfqm_pkg::word_char(2'd1, 3'd0)) begin
                        m_word  = slfqm_pkg::QK_IB;
                        m_pos   = 3'd1;
                        m_phase = slfqm_pkg::PH_WORD;
                    end else if (upper_c == slfqm_pkg::word_char(2'd2, 3'd0)) begin
                        m_word  = slfqm_pkg::QK_BUILD;
                        m_pos   = 3'd1;
                        m_phase = slfqm_pkg::PH_WORD;
                    end else if (upper_c == slfqm_pkg::word_char(2'd3, 3'd0)) begin
                        m_word  = slfqm_pkg::QK_OPT;
                        m_pos   = 3'd1;
                        m_phase = slfqm_pkg::PH_WORD;
                    end
                end
            end
            slfqm_pkg::PH_WORD: begin
                if (r_pos < cur_len && slfqm_pkg::word_char(cur_w, r_pos) == upper_c) begin
                    m_pos = r_pos + 3'd1;
                    if (m_pos >= cur_len) begin
                        m_phase = slfqm_pkg::PH_TRAIL;
                    end
                end else begin
                    m_phase = slfqm_pkg::PH_FAIL;
                end
            end
            slfqm_pkg::PH_TRAIL: begin
                if (!slfqm_pkg::is_blank(i_char_in)) begin
                    m_phase = slfqm_pkg::PH_FAIL;
                end
            end
            default: begin
                m_phase = r_phase;
            end
        endcase
    end

    // Framing decision for the incoming character
    always_comb begin
        logic swallow;
        logic end_frm;
        logic query;
        logic [1:0] ev;

        swallow  = 1'b0;
        end_frm  = 1'b0;
        query    = 1'b0;
        ev       = slfqm_pkg::EV_NONE;

        n_tail   = slfqm_pkg::TAIL_NONE;
        n_fill   = r_fill;
        n_ovf    = r_ovf;
        n_phase  = r_phase;
        n_word   = r_word;
        n_pos    = r_pos;

        n_event  = slfqm_pkg::EV_NONE;
        n_marker = 1'b0;
        n_length = '0;
        n_kind   = slfqm_pkg::QK_NONE;
        n_stored = 1'b0;
        n_index  = '0;
        n_byte   = '0;

        // Swallow the line ending that trails a terminator
        if (r_tail == slfqm_pkg::TAIL_LF) begin
            swallow = (i_char_in == slfqm_pkg::CH_LF);
        end else if (r_tail == slfqm_pkg::TAIL_ANY) begin
            if (i_char_in == slfqm_pkg::CH_CR) begin
                swallow = 1'b1;
                n_tail  = slfqm_pkg::TAIL_LF;
            end else if (i_char_in == slfqm_pkg::CH_LF) begin
                swallow = 1'b1;
            end
        end

        if (!swallow) begin
            priority if (i_char_in == slfqm_pkg::CH_CR) begin
                end_frm = 1'b1;
                ev      = slfqm_pkg::EV_EXECUTE;
                n_tail  = slfqm_pkg::TAIL_LF;
            end else if (i_char_in == slfqm_pkg::CH_LF) begin
                end_frm = 1'b1;
                ev      = slfqm_pkg::EV_EXECUTE;
            end else if (i_char_in == slfqm_pkg::CH_QUERY) begin
                end_frm = 1'b1;
                query   = 1'b1;
                ev      = slfqm_pkg::EV_EXECUTE;
                n_tail  = slfqm_pkg::TAIL_ANY;
            end else if (i_char_in == slfqm_pkg::CH_BANG) begin
                end_frm = 1'b1;
                ev      = slfqm_pkg::EV_DEFER;
                n_tail  = slfqm_pkg::TAIL_ANY;
            end else if (r_fill < slfqm_pkg::FILL_W'(slfqm_pkg::MAX_LEN)) begin
                n_stored = 1'b1;
                n_index  = slfqm_pkg::INDEX_W'(r_fill);
                n_byte   = i_char_in;
                n_fill   = r_fill + 1'b1;
                n_phase  = m_phase;
                n_word   = m_word;
                n_pos    = m_pos;
            end else begin
                // buffer full: character dropped, frame will end as overflow
                n_ovf = 1'b1;
            end
        end

        if (end_frm) begin
            n_event  = r_ovf ? slfqm_pkg::EV_OVERFLOW : ev;
            n_marker = query;
            n_length = slfqm_pkg::LEN_W'(r_fill);
            n_kind   = (query && r_phase == slfqm_pkg::PH_TRAIL) ? r_word : slfqm_pkg::QK_NONE;
            n_fill   = '0;
            n_ovf    = 1'b0;
            n_phase  = slfqm_pkg::PH_LEAD;
            n_word   = '0;
            n_pos    = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail      <= slfqm_pkg::TAIL_NONE;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_phase     <= slfqm_pkg::PH_LEAD;
            r_word      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_tail  <= n_tail;
                r_fill  <= n_fill;
                r_ovf   <= n_ovf;
                r_phase <= n_phase;
                r_word  <= n_word;
                r_pos   <= n_pos;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_event  <= n_event;
            r_marker <= n_marker;
            r_length <= n_length;
            r_kind   <= n_kind;
            r_stored <= n_stored;
            r_index  <= n_index;
            r_byte   <= n_byte;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_event  = r_event;
    assign o_frame_marker = r_marker;
    assign o_frame_length = r_length;
    assign o_query_kind   = r_kind;
    assign o_byte_stored  = r_stored;
    assign o_store_index  = r_index;
    assign o_stored_byte  = r_byte;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= slfqm_pkg::FILL_W'(slfqm_pkg::MAX_LEN))
        else $error("fill count beyond buffer capacity");

    a_store_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_stored) |-> (r_event == slfqm_pkg::EV_NONE))
        else $error("stored byte reported together with a frame end");

    a_kind_needs_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != slfqm_pkg::QK_NONE)
            |-> (r_marker && r_event != slfqm_pkg::EV_NONE))
        else $error("query word reported outside a query frame");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_fill == slfqm_pkg::FILL_W'(slfqm_pkg::MAX_LEN)))
        else $error("overflow flagged while buffer not full");
`endif

endmodule

FILE: sim/tb_serial_line_framer_query_match_core.sv
// Testbench for the serial line framer: per-character prediction, scoreboarding and random stimulus.
`timescale 1ns / 100ps

module tb_serial_line_framer_query_match_core;

    // Cycles with no transaction on either side before the run is abandoned
    localparam int QUIET_LIMIT = 5000;
    // Rough size of the random part, in characters
    localparam int CHAR_TARGET = 1700;

    // One result transaction, fields in port order
    typedef struct packed {
        logic [slfqm_pkg::EVENT_W-1:0] ev;
        logic                          marker;
        logic [slfqm_pkg::LEN_W-1:0]   len;
        logic [slfqm_pkg::KIND_W-1:0]  kind;
        logic                          stored;
        logic [slfqm_pkg::INDEX_W-1:0] idx;
        logic [7:0]                    data;
    } t_frame_result;

    // Framer predictor plus the queue of results still owed by the block
    class t_framer_scoreboard;
        logic [1:0]      tail;
        int unsigned     fill;
        bit              dropped;
        logic [1:0]      phase;
        logic [2:0]      cand;
        int unsigned     pos;
        string           words[4];
        t_frame_result   awaited[$];
        int unsigned     failures;

        function new();
            // Word order follows the query codes, so cand doubles as the code
            words = '{"STB", "IB", "BUILD", "OPT"};
            tail = slfqm_pkg::TAIL_NONE;
            fill = 0;
            dropped = 0;
            failures = 0;
            restart_match();
        endfunction

        function void restart_match();
            phase = slfqm_pkg::PH_LEAD;
            cand = slfqm_pkg::QK_NONE;
            pos = 0;
        endfunction

        function void track_word(logic [7:0] c);
            logic [7:0] up;
            bit         blank;
            int         w;
            up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
            blank = (c == slfqm_pkg::CH_SPACE) || (c == slfqm_pkg::CH_TAB);
            case (phase)
                slfqm_pkg::PH_LEAD: begin
                    if (!blank) begin
                        phase = slfqm_pkg::PH_FAIL;
                        for (w = 0; w < 4; w++) begin
                            if (words[w].getc(0) == up) begin
                                cand = 3'(w + 1);
                                pos = 1;
                                phase = slfqm_pkg::PH_WORD;
                            end
                        end
                    end
                end
                slfqm_pkg::PH_WORD: begin
                    w = (cand - 1) & 3;
                    if (pos < words[w].len() && words[w].getc(pos) == up) begin
                        pos++;
                        if (pos >= words[w].len()) begin
                            phase = slfqm_pkg::PH_TRAIL;
                        end
                    end else begin
                        phase = slfqm_pkg::PH_FAIL;
                    end
                end
                slfqm_pkg::PH_TRAIL: begin
                    if (!blank) begin
                        phase = slfqm_pkg::PH_FAIL;
                    end
                end
                default: ;
            endcase
        endfunction

        function void close_frame(inout t_frame_result r, input logic [1:0] ev, input bit query);
            r.ev = dropped ? slfqm_pkg::EV_OVERFLOW : ev;
            r.marker = query;
            r.len = slfqm_pkg::LEN_W'(fill);
            r.kind = (query && phase == slfqm_pkg::PH_TRAIL) ? cand : slfqm_pkg::QK_NONE;
            fill = 0;
            dropped = 0;
            restart_match();
        endfunction

        function t_frame_result next_outcome(logic [7:0] c);
            t_frame_result r;
            r = '0;
            // Swallowed terminators give an all-zero result
            if (tail == slfqm_pkg::TAIL_LF) begin
                tail = slfqm_pkg::TAIL_NONE;
                if (c == slfqm_pkg::CH_LF) return r;
            end else if (tail == slfqm_pkg::TAIL_ANY) begin
                tail = slfqm_pkg::TAIL_NONE;
                if (c == slfqm_pkg::CH_CR) begin
                    tail = slfqm_pkg::TAIL_LF;
                    return r;
                end
                if (c == slfqm_pkg::CH_LF) return r;
            end else begin
                tail = slfqm_pkg::TAIL_NONE;
            end

            if (c == slfqm_pkg::CH_CR) begin
                close_frame(r, slfqm_pkg::EV_EXECUTE, 1'b0);
                tail = slfqm_pkg::TAIL_LF;
            end else if (c == slfqm_pkg::CH_LF) begin
                close_frame(r, slfqm_pkg::EV_EXECUTE, 1'b0);
            end else if (c == slfqm_pkg::CH_QUERY) begin
                close_frame(r, slfqm_pkg::EV_EXECUTE, 1'b1);
                tail = slfqm_pkg::TAIL_ANY;
            end else if (c == slfqm_pkg::CH_BANG) begin
                close_frame(r, slfqm_pkg::EV_DEFER, 1'b0);
                tail = slfqm_pkg::TAIL_ANY;
            end else if (fill < slfqm_pkg::MAX_LEN) begin
                r.stored = 1'b1;
                r.idx = slfqm_pkg::INDEX_W'(fill);
                r.data = c;
                fill++;
                track_word(c);
            end else begin
                dropped = 1'b1;
            end
            return r;
        endfunction

        function void note_char(logic [7:0] c);
            awaited.push_back(next_outcome(c));
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result transaction, got %h", $time, got);
                failures++;
                return;
            end
            want = awaited.pop_front();
            check_field("frame_event", want.ev, got.ev);
            check_field("frame_marker", want.marker, got.marker);
            check_field("frame_length", want.len, got.len);
            check_field("query_kind", want.kind, got.kind);
            check_field("byte_stored", want.stored, got.stored);
            check_field("store_index", want.idx, got.idx);
            check_field("stored_byte", want.data, got.data);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // DUT connections, all inputs known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_char_in   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_frame_event;
    logic       o_frame_marker;
    logic [6:0] o_frame_length;
    logic [2:0] o_query_kind;
    logic       o_byte_stored;
    logic [5:0] o_store_index;
    logic [7:0] o_stored_byte;

    t_framer_scoreboard sb;
    int unsigned      chars_sent   = 0;
    int unsigned      quiet_cycles = 0;
    bit               tx_steady    = 0;
    bit               rx_steady    = 0;
    int               rx_hold      = 0;
    int               rx_gap;

    serial_line_framer_query_match_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_in      (i_char_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_event  (o_frame_event),
        .o_frame_marker (o_frame_marker),
        .o_frame_length (o_frame_length),
        .o_query_kind   (o_query_kind),
        .o_byte_stored  (o_byte_stored),
        .o_store_index  (o_store_index),
        .o_stored_byte  (o_stored_byte)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one; none in a steady stretch
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? slfqm_pkg::CH_TAB : slfqm_pkg::CH_SPACE;
    endfunction

    // Printable character that never ends a frame
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        if (c == slfqm_pkg::CH_QUERY || c == slfqm_pkg::CH_BANG) c = 8'h2D;
        return c;
    endfunction

    // Receiver: check every accepted result, then choose ready for the next edge.
    // Outputs are read straight after the edge, before any register update lands.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result({o_frame_event, o_frame_marker, o_frame_length, o_query_kind,
                                 o_byte_stored, o_store_index, o_stored_byte});
            end
            if ($urandom_range(0, 299) == 0) rx_steady <= !rx_steady;
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                rx_gap = pick_gap(rx_steady);
                if (rx_gap > 0) begin
                    rx_hold <= rx_gap - 1;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: counts edges with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // Optional idle first, then hold valid until the transaction is taken.
    // Valid is left high on return so back-to-back characters need no second assignment.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_char(c);
        chars_sent++;
    endtask

    // Sender holds off until the block has handed back everything it owes
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // One frame of random content: mostly query words, also free text, raw noise,
    // overlong lines and empty ones, closed by a random terminator and tail
    task automatic send_frame();
        logic [7:0] txt[$];
        int         mode;
        int         w;
        string      wd;
        logic [7:0] c;
        mode = $urandom_range(0, 99);
        w = $urandom_range(0, 3);
        wd = sb.words[w];
        if (mode < 45 || (mode >= 82 && mode < 90)) begin
            // Word framed by blanks, letters in random case
            repeat ($urandom_range(0, 3)) txt.push_back(pick_blank());
            for (int i = 0; i < wd.len(); i++) begin
                c = wd.getc(i);
                txt.push_back($urandom_range(0, 1) ? (c | 8'h20) : c);
            end
            repeat ($urandom_range(0, 3)) txt.push_back(pick_blank());
            if (mode < 45 && $urandom_range(0, 4) == 0) begin
                txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            end
            if (mode >= 82) begin
                // Pad to a full buffer so the rest is dropped but the word still counts
                while (txt.size() < slfqm_pkg::MAX_LEN) txt.push_back(pick_blank());
                repeat ($urandom_range(1, 4)) txt.push_back(pick_plain());
            end
        end else if (mode < 68) begin
            repeat ($urandom_range(0, 12)) txt.push_back(pick_plain());
        end else if (mode < 82) begin
            repeat ($urandom_range(0, 8)) txt.push_back(8'($urandom_range(0, 255)));
        end else if (mode < 95) begin
            repeat ($urandom_range(60, 72)) txt.push_back(pick_plain());
        end

        // Terminator, forced to a query mark for the padded word frames
        case ((mode >= 82 && mode < 90) ? 2 : $urandom_range(0, 3))
            0:       txt.push_back(slfqm_pkg::CH_CR);
            1:       txt.push_back(slfqm_pkg::CH_LF);
            2:       txt.push_back(slfqm_pkg::CH_QUERY);
            default: txt.push_back(slfqm_pkg::CH_BANG);
        endcase
        repeat ($urandom_range(0, 2)) begin
            txt.push_back($urandom_range(0, 1) ? slfqm_pkg::CH_CR : slfqm_pkg::CH_LF);
        end

        foreach (txt[i]) send_char(txt[i]);
    endtask

    initial begin
        logic [7:0] opening[$];
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every word as a query, CR LF and lone LF after '?', a defer with a
        // CR whose expected LF never comes, CR LF after a plain line, and byte extremes
        opening = '{"s", "T", "b", slfqm_pkg::CH_QUERY, slfqm_pkg::CH_CR, slfqm_pkg::CH_LF,
                    "B", "U", "I", "L", "D", slfqm_pkg::CH_TAB, slfqm_pkg::CH_QUERY,
                    slfqm_pkg::CH_LF,
                    "i", "b", slfqm_pkg::CH_BANG, slfqm_pkg::CH_CR,
                    "x", slfqm_pkg::CH_CR, slfqm_pkg::CH_LF,
                    "o", "p", "t", slfqm_pkg::CH_QUERY,
                    8'hFF, 8'h00, slfqm_pkg::CH_LF,
                    " ", "I", "b", " ", slfqm_pkg::CH_QUERY};
        foreach (opening[i]) send_char(opening[i]);
        wait_all_results();

        while (chars_sent < CHAR_TARGET) begin
            if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
            if ($urandom_range(0, 59) == 0) wait_all_results();
            send_frame();
        end

        // Drain, then let the result register flush anything stray
        wait_all_results();
        repeat (4) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/slfqm_pkg.sv
design/serial_line_framer_query_match_core.sv
sim/tb_serial_line_framer_query_match_core.sv
